// File: rtl/core/msbd_pkg.sv
package msbd_pkg;

  // fixed field widths
  localparam int CmdW     = 16;
  localparam int LimW     = 16;
  localparam int DbandW   = 15;
  localparam int MagW     = 16;
  localparam int VW       = LimW + 1;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;

  // parameter defaults
  localparam int DutyBitsDef = 8;
  localparam int FracBitsDef = 14;

  // register indexes
  localparam logic [CfgIdxW-1:0] CfgDriveMode    = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgLimitLow     = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgLimitHigh    = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgDeadband     = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgInvertDir    = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgDriveEnabled = 3'd5;

  typedef enum logic [1:0] {
    ModeHbridge = 2'd0,
    ModeDualPwm = 2'd1,
    ModePwmDir  = 2'd2,
    ModeInvalid = 2'd3
  } drive_mode_e;

  typedef struct packed {
    drive_mode_e              drive_mode;
    logic signed [LimW-1:0]   limit_low;
    logic signed [LimW-1:0]   limit_high;
    logic [DbandW-1:0]        deadband;
    logic                     invert_dir;
    logic                     drive_enabled;
  } cfg_t;

endpackage

// File: rtl/core/msbd_remap.sv
module msbd_remap #(
  parameter int FRAC_BITS = msbd_pkg::FracBitsDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  msbd_pkg::cfg_t                   cfg_i,
  input  logic                             valid_i,
  output logic                             ready_o,
  input  logic signed [msbd_pkg::CmdW-1:0] cmd_i,
  output logic                             valid_o,
  input  logic                             ready_i,
  output logic signed [msbd_pkg::VW-1:0]   v_o
);
  import msbd_pkg::*;

  localparam int CW  = (FRAC_BITS + 2 > CmdW) ? FRAC_BITS + 2 : CmdW;
  localparam int PW  = CW + 1;
  localparam int DW  = LimW + 1;
  localparam int PRW = PW + DW;

  typedef logic signed [CW-1:0]  c_t;
  typedef logic signed [PW-1:0]  p_t;
  typedef logic signed [DW-1:0]  d_t;
  typedef logic signed [PRW-1:0] pr_t;
  typedef logic signed [VW-1:0]  v_t;

  localparam c_t  OneC = c_t'(64'sd1 <<< FRAC_BITS);
  localparam pr_t Bias = pr_t'((64'sd1 <<< (FRAC_BITS + 1)) - 64'sd1);

  logic [2:0] valid_q;
  logic       rdy1, rdy2, rdy3;

  // per-stage ready chain, bubbles collapse
  assign rdy3    = !valid_q[2] || ready_i;
  assign rdy2    = !valid_q[1] || rdy3;
  assign rdy1    = !valid_q[0] || rdy2;
  assign ready_o = rdy1;
  assign valid_o = valid_q[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (rdy1) valid_q[0] <= valid_i;
      if (rdy2) valid_q[1] <= valid_q[0];
      if (rdy3) valid_q[2] <= valid_q[1];
    end
  end

  // stage 1: enable gate, clamp, offset and span
  c_t c_raw, c_clamp;
  p_t p_d, p_q;
  d_t d_d, d_q;

  always_comb begin
    c_raw = cfg_i.drive_enabled ? c_t'(cmd_i) : '0;
    if (c_raw > OneC) begin
      c_clamp = OneC;
    end else if (c_raw < -OneC) begin
      c_clamp = -OneC;
    end else begin
      c_clamp = c_raw;
    end
    p_d = p_t'(c_clamp) + p_t'(OneC);
    d_d = d_t'(cfg_i.limit_high) - d_t'(cfg_i.limit_low);
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      p_q <= p_d;
      d_q <= d_d;
    end
  end

  // stage 2: scale by span
  pr_t prod_d, prod_q;
  assign prod_d = pr_t'(p_q) * pr_t'(d_q);

  always_ff @(posedge clk_i) begin
    if (rdy2) prod_q <= prod_d;
  end

  // stage 3: divide by two units toward zero, add low limit
  pr_t biased, quot;
  v_t  v_d, v_q;

  always_comb begin
    biased = prod_q + (prod_q[PRW-1] ? Bias : pr_t'(0));
    quot   = biased >>> (FRAC_BITS + 1);
    v_d    = v_t'(cfg_i.limit_low) + v_t'(quot);
  end

  always_ff @(posedge clk_i) begin
    if (rdy3) v_q <= v_d;
  end

  assign v_o = v_q;

endmodule

// File: rtl/core/msbd_shape.sv
module msbd_shape #(
  parameter int DUTY_BITS = msbd_pkg::DutyBitsDef,
  parameter int FRAC_BITS = msbd_pkg::FracBitsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  msbd_pkg::cfg_t                 cfg_i,
  input  logic                           valid_i,
  output logic                           ready_o,
  input  logic signed [msbd_pkg::VW-1:0] v_i,
  output logic                           valid_o,
  input  logic                           ready_i,
  output logic [DUTY_BITS-1:0]           duty_main_o,
  output logic [DUTY_BITS-1:0]           duty_second_o,
  output logic                           line_a_o,
  output logic                           line_b_o,
  output logic                           fault_o
);
  import msbd_pkg::*;

  localparam int PRW = MagW + DUTY_BITS;
  localparam logic [DUTY_BITS-1:0] DutyMax = {DUTY_BITS{1'b1}};

  logic [2:0] valid_q;
  logic       rdy4, rdy5, rdy6;

  assign rdy6    = !valid_q[2] || ready_i;
  assign rdy5    = !valid_q[1] || rdy6;
  assign rdy4    = !valid_q[0] || rdy5;
  assign ready_o = rdy4;
  assign valid_o = valid_q[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (rdy4) valid_q[0] <= valid_i;
      if (rdy5) valid_q[1] <= valid_q[0];
      if (rdy6) valid_q[2] <= valid_q[1];
    end
  end

  // stage 4: magnitude, deadband, direction after inversion
  logic [VW-1:0]   abs_v;
  logic [MagW-1:0] mag_d, mag_q;
  logic            in_band, pos_d, neg_d, pos4_q, neg4_q;

  always_comb begin
    abs_v   = v_i[VW-1] ? VW'(-v_i) : VW'(v_i);
    mag_d   = abs_v[MagW-1:0];
    in_band = mag_d < MagW'(cfg_i.deadband);
    pos_d   = !in_band && (cfg_i.invert_dir ? v_i[VW-1] : (!v_i[VW-1] && (v_i != '0)));
    neg_d   = !in_band && (cfg_i.invert_dir ? (!v_i[VW-1] && (v_i != '0)) : v_i[VW-1]);
    if (in_band) mag_d = '0;
  end

  always_ff @(posedge clk_i) begin
    if (rdy4) begin
      mag_q  <= mag_d;
      pos4_q <= pos_d;
      neg4_q <= neg_d;
    end
  end

  // stage 5: magnitude times full-scale duty
  logic [PRW-1:0] prod_q;
  logic           pos5_q, neg5_q;

  always_ff @(posedge clk_i) begin
    if (rdy5) begin
      prod_q <= PRW'(mag_q) * PRW'(DutyMax);
      pos5_q <= pos4_q;
      neg5_q <= neg4_q;
    end
  end

  // stage 6: drop fraction, saturate, route by driver mode
  logic [PRW-1:0]       duty_wide;
  logic [DUTY_BITS-1:0] duty;
  logic [DUTY_BITS-1:0] main_d, sec_d;
  logic                 la_d, lb_d, flt_d;

  always_comb begin
    duty_wide = prod_q >> FRAC_BITS;
    duty      = (duty_wide > PRW'(DutyMax)) ? DutyMax : duty_wide[DUTY_BITS-1:0];
    main_d    = '0;
    sec_d     = '0;
    la_d      = 1'b0;
    lb_d      = 1'b0;
    flt_d     = 1'b0;
    case (cfg_i.drive_mode)
      ModeHbridge: begin
        main_d = duty;
        la_d   = pos5_q;
        lb_d   = neg5_q;
      end
      ModeDualPwm: begin
        if (pos5_q) main_d = duty;
        else        sec_d  = duty;
      end
      ModePwmDir: begin
        main_d = duty;
        la_d   = pos5_q;
      end
      default: begin
        flt_d = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (rdy6) begin
      duty_main_o   <= main_d;
      duty_second_o <= sec_d;
      line_a_o      <= la_d;
      line_b_o      <= lb_d;
      fault_o       <= flt_d;
    end
  end

endmodule

// File: rtl/core/motor_speed_to_bridge_drive.sv
// channel | direction | handshake             | payload
// in      | input     | in_valid_i/in_stall_o   | speed_cmd_i
// out     | output    | out_valid_o/out_stall_i | duty_main_o, duty_second_o, line_a_o,
//         |           |                         | line_b_o, fault_o
// cfg     | input     | cfg_we_i                | cfg_idx_i, cfg_data_i
//
// six register stages: clamp, span multiply, divide and offset, deadband,
// duty multiply, saturate and mode routing
// one transfer per cycle while out_stall_i is low;
// each stage holds only while its successor is full
// reset clears the valid bits and loads the register reset values
// a stall on the output fills empty stages first, then raises in_stall_o
module motor_speed_to_bridge_drive #(
  parameter int DUTY_BITS = msbd_pkg::DutyBitsDef,
  parameter int FRAC_BITS = msbd_pkg::FracBitsDef
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [msbd_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [msbd_pkg::CfgDataW-1:0]        cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [msbd_pkg::CmdW-1:0]     speed_cmd_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [DUTY_BITS-1:0]                 duty_main_o,
  output logic [DUTY_BITS-1:0]                 duty_second_o,
  output logic                                 line_a_o,
  output logic                                 line_b_o,
  output logic                                 fault_o
);
  import msbd_pkg::*;

  cfg_t cfg_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.drive_mode    <= ModeHbridge;
      cfg_q.limit_low     <= -16'sd16384;
      cfg_q.limit_high    <= 16'sd16384;
      cfg_q.deadband      <= 15'd4915;
      cfg_q.invert_dir    <= 1'b0;
      cfg_q.drive_enabled <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgDriveMode:    cfg_q.drive_mode    <= drive_mode_e'(cfg_data_i[1:0]);
        CfgLimitLow:     cfg_q.limit_low     <= cfg_data_i[LimW-1:0];
        CfgLimitHigh:    cfg_q.limit_high    <= cfg_data_i[LimW-1:0];
        CfgDeadband:     cfg_q.deadband      <= cfg_data_i[DbandW-1:0];
        CfgInvertDir:    cfg_q.invert_dir    <= cfg_data_i[0];
        CfgDriveEnabled: cfg_q.drive_enabled <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic                 remap_ready, mid_valid, mid_ready;
  logic signed [VW-1:0] mid_v;

  assign in_stall_o = !remap_ready;

  // command to remapped value
  msbd_remap #(
    .FRAC_BITS(FRAC_BITS)
  ) u_remap (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (in_valid_i),
    .ready_o (remap_ready),
    .cmd_i   (speed_cmd_i),
    .valid_o (mid_valid),
    .ready_i (mid_ready),
    .v_o     (mid_v)
  );

  // remapped value to duties and lines
  msbd_shape #(
    .DUTY_BITS(DUTY_BITS),
    .FRAC_BITS(FRAC_BITS)
  ) u_shape (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .valid_i       (mid_valid),
    .ready_o       (mid_ready),
    .v_i           (mid_v),
    .valid_o       (out_valid_o),
    .ready_i       (!out_stall_i),
    .duty_main_o   (duty_main_o),
    .duty_second_o (duty_second_o),
    .line_a_o      (line_a_o),
    .line_b_o      (line_b_o),
    .fault_o       (fault_o)
  );

endmodule

// File: rtl/core/msbd_checker.sv
module msbd_checker #(
  parameter int DUTY_BITS = msbd_pkg::DutyBitsDef
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input logic [DUTY_BITS-1:0] duty_main_o,
  input logic [DUTY_BITS-1:0] duty_second_o,
  input logic                 line_a_o,
  input logic                 line_b_o,
  input logic                 fault_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(duty_main_o)
      && $stable(duty_second_o) && $stable(fault_o))
    else $error("stalled result changed");

  // fault silences all drive outputs
  a_fault_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && fault_o |-> duty_main_o == '0 && duty_second_o == '0
      && !line_a_o && !line_b_o)
    else $error("drive output active with fault");

  // bridge never drives both lines
  a_no_shoot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(line_a_o && line_b_o))
    else $error("both bridge lines high");

  // reverse duty excludes every other drive output
  a_reverse_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && duty_second_o != '0 |-> duty_main_o == '0 && !line_a_o
      && !line_b_o && !fault_o)
    else $error("reverse duty with other outputs active");

endmodule

bind motor_speed_to_bridge_drive msbd_checker #(.DUTY_BITS(DUTY_BITS)) u_msbd_checker (.*);

// File: bench/tb_motor_speed_to_bridge_drive.sv
module tb_motor_speed_to_bridge_drive;
  import msbd_pkg::*;

  localparam int DutyW       = DutyBitsDef;
  localparam longint OneQ    = longint'(1) << FracBitsDef;
  localparam longint DutyMax = (longint'(1) << DutyBitsDef) - 1;
  localparam int SettleCycles = 12;
  localparam int CycleLimit   = 300000;
  localparam int ItemsPerSetup = 78;

  // register indexes that decode to nothing
  localparam logic [CfgIdxW-1:0] CfgSpareA = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgSpareB = 3'd7;

  typedef struct packed {
    logic [DutyW-1:0] duty_main;
    logic [DutyW-1:0] duty_second;
    logic             line_a;
    logic             line_b;
    logic             fault;
  } drive_out_t;

  typedef struct {
    logic signed [CmdW-1:0] cmd;
    drive_out_t             out;
  } drive_due_t;

  typedef struct {
    logic                   is_reg;
    logic [CfgIdxW-1:0]     idx;
    logic [CfgDataW-1:0]    data;
    logic signed [CmdW-1:0] cmd;
    logic                   fixed;
    drive_out_t             want;
  } plan_row_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CfgIdxW-1:0]     cfg_idx_i;
  logic [CfgDataW-1:0]    cfg_data_i;
  logic                   in_valid_i;
  logic                   in_stall_o;
  logic signed [CmdW-1:0] speed_cmd_i;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  logic [DutyW-1:0]       duty_main_o;
  logic [DutyW-1:0]       duty_second_o;
  logic                   line_a_o;
  logic                   line_b_o;
  logic                   fault_o;

  cfg_t       regs;
  drive_due_t drive_due_q[$];
  plan_row_t  plan_q[$];
  int         idle_in_pct;
  int         idle_out_pct;
  int         cycle_cnt = 0;
  int         mismatch_cnt;
  int         cmd_cnt;
  int         result_cnt;
  int         setup_cnt;

  motor_speed_to_bridge_drive uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .speed_cmd_i   (speed_cmd_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .duty_main_o   (duty_main_o),
    .duty_second_o (duty_second_o),
    .line_a_o      (line_a_o),
    .line_b_o      (line_b_o),
    .fault_o       (fault_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // expected drive outputs for one speed command under the current registers
  function automatic drive_out_t predict_drive(input logic signed [CmdW-1:0] cmd);
    longint     c, lo, hi, v, mag, duty;
    drive_out_t r;
    r = '0;
    c = 0;
    if (regs.drive_enabled) c = longint'(cmd);
    if (c > OneQ) c = OneQ;
    if (c < -OneQ) c = -OneQ;
    lo = longint'($signed(regs.limit_low));
    hi = longint'($signed(regs.limit_high));
    v = lo + ((c + OneQ) * (hi - lo)) / (2 * OneQ);
    mag = (v < 0) ? -v : v;
    if (mag < longint'(regs.deadband)) v = 0;
    if (regs.invert_dir) v = -v;
    mag = (v < 0) ? -v : v;
    duty = (mag * DutyMax) >> FracBitsDef;
    if (duty > DutyMax) duty = DutyMax;
    case (regs.drive_mode)
      ModeHbridge: begin
        r.duty_main = DutyW'(duty);
        r.line_a = (v > 0);
        r.line_b = (v < 0);
      end
      ModeDualPwm: begin
        if (v > 0) r.duty_main = DutyW'(duty);
        else r.duty_second = DutyW'(duty);
      end
      ModePwmDir: begin
        r.duty_main = DutyW'(duty);
        r.line_a = (v > 0);
      end
      default: begin
        r.fault = 1'b1;
      end
    endcase
    return r;
  endfunction

  function automatic void plan_reg(input logic [CfgIdxW-1:0] idx,
                                   input logic [CfgDataW-1:0] data);
    plan_row_t row;
    row = '{is_reg: 1'b1, idx: idx, data: data, cmd: '0, fixed: 1'b0, want: '0};
    plan_q.push_back(row);
  endfunction

  function automatic void plan_cmd(input logic signed [CmdW-1:0] cmd, input logic fixed,
                                   input drive_out_t want);
    plan_row_t row;
    row = '{is_reg: 1'b0, idx: '0, data: '0, cmd: cmd, fixed: fixed, want: want};
    plan_q.push_back(row);
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= 100) $display("mismatch at cycle %0d: %s", cycle_cnt, msg);
  endtask

  task automatic check_field(input string name, input int got, input int want,
                             input logic signed [CmdW-1:0] cmd);
    if (got != want) begin
      report_mismatch($sformatf("%s got %0d want %0d for speed %0d", name, got, want, cmd));
    end
  endtask

  // compare one result transfer against the oldest pending expectation
  task automatic check_result();
    drive_due_t due;
    result_cnt++;
    if (drive_due_q.size() == 0) begin
      report_mismatch("result transfer with nothing pending");
    end else begin
      due = drive_due_q.pop_front();
      check_field("duty_main", int'(duty_main_o), int'(due.out.duty_main), due.cmd);
      check_field("duty_second", int'(duty_second_o), int'(due.out.duty_second), due.cmd);
      check_field("line_a", int'(line_a_o), int'(due.out.line_a), due.cmd);
      check_field("line_b", int'(line_b_o), int'(due.out.line_b), due.cmd);
      check_field("fault", int'(fault_o), int'(due.out.fault), due.cmd);
    end
  endtask

  // one register write, mirrored into the local copy
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CfgDriveMode:    regs.drive_mode = drive_mode_e'(data[1:0]);
      CfgLimitLow:     regs.limit_low = data;
      CfgLimitHigh:    regs.limit_high = data;
      CfgDeadband:     regs.deadband = data[DbandW-1:0];
      CfgInvertDir:    regs.invert_dir = data[0];
      CfgDriveEnabled: regs.drive_enabled = data[0];
      default: ;
    endcase
  endtask

  // stop sending and let every pending result drain
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (drive_due_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // one command transfer with random sender gaps; valid holds while stalled
  task automatic push_cmd(input logic signed [CmdW-1:0] cmd, input logic fixed,
                          input drive_out_t want);
    drive_due_t due;
    while ($urandom_range(0, 99) < idle_in_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    speed_cmd_i <= cmd;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    due.cmd = cmd;
    due.out = fixed ? want : predict_drive(cmd);
    drive_due_q.push_back(due);
    cmd_cnt++;
  endtask

  // receiver: random stall, check on every result transfer
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) check_result();
    out_stall_i <= ($urandom_range(0, 99) < idle_out_pct);
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("FAIL motor_speed_to_bridge_drive");
      $finish;
    end
  end

  initial begin
    int                     ph, k, n;
    logic signed [CmdW-1:0] cmd, lo_v, hi_v;
    logic [CfgDataW-1:0]    junk;
    logic [DbandW-1:0]      db;
    drive_mode_e            mode;

    cfg_we_i     = 1'b0;
    cfg_idx_i    = '0;
    cfg_data_i   = '0;
    in_valid_i   = 1'b0;
    speed_cmd_i  = '0;
    rst_ni       = 1'b0;
    mismatch_cnt = 0;
    cmd_cnt      = 0;
    result_cnt   = 0;
    setup_cnt    = 0;
    idle_in_pct  = 16;
    idle_out_pct = 62;
    regs.drive_mode    = ModeHbridge;
    regs.limit_low     = -16'sd16384;
    regs.limit_high    = 16'sd16384;
    regs.deadband      = 15'd4915;
    regs.invert_dir    = 1'b0;
    regs.drive_enabled = 1'b1;

    // directed: extremes, clamp, deadband edges, each mode, inversion, limits
    plan_cmd(-16'sd32768, 1'b1, drive_out_t'{8'd255, 8'd0, 1'b0, 1'b1, 1'b0});
    plan_cmd(16'sd32767, 1'b1, drive_out_t'{8'd255, 8'd0, 1'b1, 1'b0, 1'b0});
    plan_cmd(16'sd0, 1'b1, drive_out_t'{8'd0, 8'd0, 1'b0, 1'b0, 1'b0});
    plan_cmd(16'sd16384, 1'b1, drive_out_t'{8'd255, 8'd0, 1'b1, 1'b0, 1'b0});
    plan_cmd(-16'sd16384, 1'b1, drive_out_t'{8'd255, 8'd0, 1'b0, 1'b1, 1'b0});
    plan_cmd(-16'sd16385, 1'b0, '0);
    plan_cmd(16'sd16385, 1'b0, '0);
    plan_cmd(16'sd4915, 1'b0, '0);
    plan_cmd(16'sd4914, 1'b0, '0);
    plan_cmd(-16'sd4915, 1'b0, '0);
    plan_cmd(-16'sd4914, 1'b0, '0);
    // dual pwm, zero speed lands on the reverse channel
    plan_reg(CfgDriveMode, 16'(ModeDualPwm));
    plan_cmd(16'sd0, 1'b0, '0);
    plan_cmd(16'sd9000, 1'b0, '0);
    plan_cmd(-16'sd9000, 1'b0, '0);
    plan_reg(CfgDriveMode, 16'(ModePwmDir));
    plan_cmd(16'sd9000, 1'b0, '0);
    plan_cmd(-16'sd9000, 1'b0, '0);
    plan_reg(CfgDriveMode, 16'(ModeInvalid));
    plan_cmd(16'sd12345, 1'b1, drive_out_t'{8'd0, 8'd0, 1'b0, 1'b0, 1'b1});
    // widest limits with inversion, including the most negative value
    plan_reg(CfgDriveMode, 16'(ModeHbridge));
    plan_reg(CfgLimitLow, 16'h8000);
    plan_reg(CfgLimitHigh, 16'h7fff);
    plan_reg(CfgInvertDir, 16'd1);
    plan_cmd(-16'sd16384, 1'b0, '0);
    plan_cmd(16'sd16384, 1'b0, '0);
    plan_cmd(16'sd0, 1'b0, '0);
    // crossed limits, no deadband, then the widest deadband
    plan_reg(CfgLimitLow, 16'sd20000);
    plan_reg(CfgLimitHigh, -16'sd20000);
    plan_reg(CfgDeadband, 16'd0);
    plan_cmd(-16'sd3000, 1'b0, '0);
    plan_cmd(16'sd5000, 1'b0, '0);
    plan_reg(CfgDeadband, 16'h7fff);
    plan_cmd(16'sd16384, 1'b0, '0);
    // unused indexes, then drive disabled
    plan_reg(CfgSpareA, 16'hffff);
    plan_reg(CfgSpareB, 16'hffff);
    plan_reg(CfgDriveEnabled, 16'd0);
    plan_cmd(16'sd32767, 1'b0, '0);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan_q[i]) begin
      if (plan_q[i].is_reg) begin
        wait_idle();
        write_reg(plan_q[i].idx, plan_q[i].data);
      end else begin
        push_cmd(plan_q[i].cmd, plan_q[i].fixed, plan_q[i].want);
      end
    end
    setup_cnt = 1;

    // random part: three idling phases, several register setups each
    for (ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin idle_in_pct = 16; idle_out_pct = 62; end
        1: begin idle_in_pct = 62; idle_out_pct = 16; end
        default: begin idle_in_pct = 0; idle_out_pct = 0; end
      endcase
      for (k = 0; k < 4; k++) begin
        wait_idle();
        setup_cnt++;
        junk = 16'($urandom);
        if ($urandom_range(0, 9) == 0) mode = ModeInvalid;
        else mode = drive_mode_e'($urandom_range(0, 2));
        write_reg(CfgDriveMode, {junk[15:2], mode});
        case ($urandom_range(0, 3))
          0: begin
            lo_v = -16'sd16384;
            hi_v = 16'sd16384;
          end
          1: begin
            lo_v = 16'(int'($urandom_range(0, 32768)) - 16384);
            hi_v = 16'(int'($urandom_range(0, 32768)) - 16384);
          end
          2: begin
            lo_v = 16'($urandom);
            hi_v = 16'($urandom);
          end
          default: begin
            lo_v = -16'sd32768;
            hi_v = 16'sd32767;
            if ($urandom_range(0, 1)) begin
              lo_v = 16'sd32767;
              hi_v = -16'sd32768;
            end
          end
        endcase
        write_reg(CfgLimitLow, lo_v);
        write_reg(CfgLimitHigh, hi_v);
        case ($urandom_range(0, 7))
          0: db = '0;
          1: db = '1;
          2: db = DbandW'($urandom);
          default: db = DbandW'($urandom_range(0, 6000));
        endcase
        write_reg(CfgDeadband, {junk[15], db});
        write_reg(CfgInvertDir, {junk[15:1], 1'($urandom_range(0, 1))});
        write_reg(CfgDriveEnabled, {junk[15:1], 1'($urandom_range(0, 4) != 0)});
        if ($urandom_range(0, 3) == 0) begin
          write_reg($urandom_range(0, 1) ? CfgSpareA : CfgSpareB, 16'($urandom));
        end

        for (n = 0; n < ItemsPerSetup; n++) begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: cmd = 16'(int'($urandom_range(0, 32768)) - 16384);
            6, 7: cmd = 16'($urandom);
            8: begin
              case ($urandom_range(0, 5))
                0: cmd = -16'sd32768;
                1: cmd = 16'sd32767;
                2: cmd = -16'sd16384;
                3: cmd = 16'sd16384;
                4: cmd = 16'sd0;
                default: cmd = 16'sd16385;
              endcase
            end
            default: begin
              // near the deadband edge, either sign
              cmd = 16'(int'(regs.deadband) + int'($urandom_range(0, 4)) - 2);
              if ($urandom_range(0, 1)) cmd = -cmd;
            end
          endcase
          push_cmd(cmd, 1'b0, '0);
        end
      end
    end

    wait_idle();
    if (drive_due_q.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", drive_due_q.size()));
    end

    $display("run covered %0d speed commands over %0d register setups", cmd_cnt, setup_cnt);
    $display("%0d result transfers checked, %0d mismatches", result_cnt, mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("PASS motor_speed_to_bridge_drive");
    end else begin
      $display("FAIL motor_speed_to_bridge_drive");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/msbd_pkg.sv
rtl/core/msbd_remap.sv
rtl/core/msbd_shape.sv
rtl/core/motor_speed_to_bridge_drive.sv
rtl/core/msbd_checker.sv
bench/tb_motor_speed_to_bridge_drive.sv
